// ===== rtl/lpfp_pkg.sv =====
`timescale 1ns / 1ps

package lpfp_pkg;

	localparam int MAX_DRIVERS = 8;
	localparam int CH_PER_DRV = 12;
	localparam int STORE_DEPTH = MAX_DRIVERS * CH_PER_DRV;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int FRAME_BYTES = 4 + 2 * CH_PER_DRV;
	localparam int CNT_W = $clog2(FRAME_BYTES);
	localparam int CHAN_W = $clog2(CH_PER_DRV);

	localparam logic [5:0] WRITE_CODE = 6'h25;
	localparam logic [4:0] CONTROL_BITS = 5'h16;
	localparam logic [6:0] BRIGHT_RESET = 7'h7F;
	localparam logic [3:0] DRV_COUNT_RESET = 4'd1;

	localparam logic [1:0] KIND_SET_CH = 2'd0;
	localparam logic [1:0] KIND_SET_LED = 2'd1;
	localparam logic [1:0] KIND_EMIT = 2'd2;

	localparam logic [1:0] CFG_DRV_COUNT = 2'd0;
	localparam logic [1:0] CFG_BRIGHT_R = 2'd1;
	localparam logic [1:0] CFG_BRIGHT_G = 2'd2;
	localparam logic [1:0] CFG_BRIGHT_B = 2'd3;

	localparam logic [1:0] SEL_HDR = 2'd0;
	localparam logic [1:0] SEL_HI = 2'd1;
	localparam logic [1:0] SEL_LO = 2'd2;

	typedef struct packed {
		logic [3:0] driver_count;
		logic [6:0] bright_red;
		logic [6:0] bright_green;
		logic [6:0] bright_blue;
	} cfg_t;

	typedef struct packed {
		logic              load_item;
		logic              wr_en;
		logic [1:0]        wr_k;
		logic              rd_en;
		logic [CHAN_W-1:0] rd_chan;
		logic              byte_load;
		logic [1:0]        byte_sel;
		logic [1:0]        hdr_idx;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       frame_ok;
		logic       out_free;
	} stat_t;

endpackage

// ===== rtl/lpfp_ctrl.sv =====
`timescale 1ns / 1ps

module lpfp_ctrl import lpfp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic [1:0]        k_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CHAN_W-1:0] chan_q;
	logic              is_last;
	logic              rd_point;

	assign in_ready = (state_q == ST_IDLE);
	assign is_last  = (cnt_q == CNT_W'(FRAME_BYTES - 1));
	// prefetch next level while the header tail or a low byte goes out
	assign rd_point = (cnt_q == CNT_W'(3))
		|| (cnt_q[0] && cnt_q >= CNT_W'(5) && !is_last);

	always_comb begin
		cmd = '0;
		cmd.load_item = in_valid && in_ready;
		cmd.wr_k      = k_q;
		cmd.rd_chan   = chan_q;
		cmd.hdr_idx   = cnt_q[1:0];
		cmd.last      = is_last;
		if (cnt_q < CNT_W'(4))
			cmd.byte_sel = SEL_HDR;
		else if (!cnt_q[0])
			cmd.byte_sel = SEL_HI;
		else
			cmd.byte_sel = SEL_LO;
		case (state_q)
			ST_EXEC: begin
				cmd.wr_en = stat.kind inside {KIND_SET_CH, KIND_SET_LED};
			end
			ST_EMIT: begin
				cmd.byte_load = stat.out_free;
				cmd.rd_en     = stat.out_free && rd_point;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			cnt_q   <= '0;
			chan_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load_item) begin
						state_q <= ST_EXEC;
						k_q     <= '0;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					if (stat.kind == KIND_SET_LED && k_q != 2'd2) begin
						state_q <= ST_EXEC;
						k_q     <= k_q + 2'd1;
					end else if (stat.kind == KIND_EMIT && stat.frame_ok) begin
						state_q <= ST_EMIT;
						cnt_q   <= '0;
						chan_q  <= CHAN_W'(CH_PER_DRV - 1);
					end
				end
				ST_EMIT: begin
					if (cmd.byte_load) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (cmd.rd_en)
							chan_q <= chan_q - CHAN_W'(1);
						if (is_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/lpfp_dpath.sv =====
`timescale 1ns / 1ps

module lpfp_dpath import lpfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [1:0]  kind,
	input  logic [7:0]  target_index,
	input  logic [15:0] value_a,
	input  logic [15:0] value_b,
	input  logic [15:0] value_c,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_byte
);

	logic [1:0]  kind_q;
	logic [7:0]  target_q;
	logic [15:0] val_a_q;
	logic [15:0] val_b_q;
	logic [15:0] val_c_q;

	logic [15:0] mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] valid_q;
	logic [15:0] rd_data_q;
	logic        rd_vld_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;

	logic [3:0]        active;
	logic [ADDR_W-1:0] limit;
	logic [9:0]        wr_chan;
	logic              wr_hit;
	logic [15:0]       wr_data;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] rd_addr;
	logic [31:0]       header;
	logic [15:0]       level;
	logic [7:0]        byte_nxt;

	assign active = (cfg.driver_count > 4'(MAX_DRIVERS)) ? 4'(MAX_DRIVERS) : cfg.driver_count;
	assign limit  = ADDR_W'(active * CH_PER_DRV);

	// an led covers three consecutive channels, computed without wrap
	assign wr_chan = (kind_q == KIND_SET_CH) ? {2'b00, target_q}
		: 10'({2'b00, target_q} * 10'd3 + {8'd0, cmd.wr_k});
	assign wr_hit  = cmd.wr_en && (wr_chan < 10'(limit));

	always_comb begin
		case (cmd.wr_k)
			2'd1:    wr_data = val_b_q;
			2'd2:    wr_data = val_c_q;
			default: wr_data = val_a_q;
		endcase
	end

	assign base    = ADDR_W'(target_q[2:0] * CH_PER_DRV);
	assign rd_addr = base + ADDR_W'(cmd.rd_chan);

	assign header = {WRITE_CODE, CONTROL_BITS, cfg.bright_red, cfg.bright_green,
		cfg.bright_blue};
	assign level  = rd_vld_q ? rd_data_q : 16'd0;

	always_comb begin
		case (cmd.byte_sel)
			SEL_HDR: begin
				case (cmd.hdr_idx)
					2'd0:    byte_nxt = header[31:24];
					2'd1:    byte_nxt = header[23:16];
					2'd2:    byte_nxt = header[15:8];
					default: byte_nxt = header[7:0];
				endcase
			end
			SEL_HI:  byte_nxt = level[15:8];
			default: byte_nxt = level[7:0];
		endcase
	end

	assign stat.kind     = kind_q;
	assign stat.frame_ok = (target_q < {4'd0, active});
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q   <= kind;
			target_q <= target_index;
			val_a_q  <= value_a;
			val_b_q  <= value_b;
			val_c_q  <= value_c;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit)
			mem[wr_chan[ADDR_W-1:0]] <= wr_data;
		if (cmd.rd_en)
			rd_data_q <= mem[rd_addr];
	end

	// entries never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_hit)
				valid_q[wr_chan[ADDR_W-1:0]] <= 1'b1;
			if (cmd.rd_en)
				rd_vld_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.byte_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_load) begin
			out_byte_q <= byte_nxt;
			last_q     <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

endmodule

// ===== rtl/led_pwm_frame_packer_unit.sv =====
`timescale 1ns / 1ps

// pwm frame packer for a chain of up to eight 12-channel led drivers. a kind 0
// transaction sets one channel level, kind 1 sets the three channels of one rgb
// led, kind 2 streams the 28-byte frame of one driver (32-bit header, then
// channels 11 down to 0, high byte first), with last_byte on the final byte.
// writes past the configured driver count and frames for absent drivers are
// dropped. a write is done in the exec state, an led write holding it until all
// three channels are written, and a frame streams one byte per cycle while
// out_ready stays high; no new transaction is taken until the last is done. the
// frame rate is set by the single output register, while the level store is
// read once per channel, prefetched one channel ahead of the output register.
// levels reset to zero with no clearing pass. configuration is taken every
// cycle and should only be written while the block is idle.
module led_pwm_frame_packer_unit import lpfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  target_index,
	input  logic [15:0] value_a,
	input  logic [15:0] value_b,
	input  logic [15:0] value_c,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.driver_count <= DRV_COUNT_RESET;
			cfg_q.bright_red   <= BRIGHT_RESET;
			cfg_q.bright_green <= BRIGHT_RESET;
			cfg_q.bright_blue  <= BRIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DRV_COUNT: cfg_q.driver_count <= cfg_data[3:0];
				CFG_BRIGHT_R:  cfg_q.bright_red   <= cfg_data;
				CFG_BRIGHT_G:  cfg_q.bright_green <= cfg_data;
				CFG_BRIGHT_B:  cfg_q.bright_blue  <= cfg_data;
				default: ;
			endcase
		end
	end

	lpfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lpfp_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.target_index (target_index),
		.value_a      (value_a),
		.value_b      (value_b),
		.value_c      (value_c),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_byte    (last_byte)
	);

endmodule
